### design/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg: shared types and codes for the gap buffer text store
// Request kind codes and the result record that goes from the sequencer to
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package gbts_pkg;

  localparam int unsigned FieldW = 17;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;

  localparam logic [KindW-1:0] KindRead      = 3'd0;
  localparam logic [KindW-1:0] KindMove      = 3'd1;
  localparam logic [KindW-1:0] KindInsert    = 3'd2;
  localparam logic [KindW-1:0] KindDelBefore = 3'd3;
  localparam logic [KindW-1:0] KindDelAfter  = 3'd4;
  localparam logic [KindW-1:0] KindDelRange  = 3'd5;
  localparam logic [KindW-1:0] KindClear     = 3'd6;

  typedef struct packed {
    logic              ok;
    logic [ByteW-1:0]  char_out;
    logic [FieldW-1:0] text_len;
    logic [FieldW-1:0] gap_position;
  } res_t;

endpackage

`default_nettype wire

### design/gbts_mem.sv
// ----------------------------------------------------------------------------
// gbts_mem: text byte store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gbts_mem #(
  parameter int unsigned CAPACITY = 65536,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i
);

  logic [7:0] mem_q [CAPACITY];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### design/gbts_ctrl.sv
// ----------------------------------------------------------------------------
// gbts_ctrl: request sequencer
// Holds the gap bounds, decodes requests, and runs the byte copy loop that
// moves the gap through the store.
// ----------------------------------------------------------------------------
`default_nettype none

module gbts_ctrl
  import gbts_pkg::*;
#(
  parameter int unsigned CAPACITY = 65536,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire logic [KindW-1:0]  kind_i,
  input  wire logic [FieldW-1:0] position_i,
  input  wire logic [FieldW-1:0] end_position_i,
  input  wire logic [ByteW-1:0]  char_in_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o,
  output logic                   rd_en_o,
  output logic      [AW-1:0]     rd_addr_o,
  input  wire logic [7:0]        rd_data_i,
  output logic                   wr_en_o,
  output logic      [AW-1:0]     wr_addr_o,
  output logic      [7:0]        wr_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > FieldW) ? CW : FieldW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMove = 2'd1;
  localparam logic [1:0] StResp = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] gf_q, gf_d, gl_q, gl_d;
  logic [CW-1:0] tgt_q, tgt_d, cnt_q, cnt_d;
  logic          ok_q, ok_d, rsel_q, rsel_d;
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;

  logic [CW-1:0] gap_w, len_w;
  logic [LW-1:0] pos_w, end_w, len_lw, gf_lw, phys_w;
  logic          accept;

  assign gap_w  = gl_q - gf_q;
  assign len_w  = CW'(CAPACITY) - gap_w;
  assign pos_w  = LW'(position_i);
  assign end_w  = LW'(end_position_i);
  assign len_lw = LW'(len_w);
  assign gf_lw  = LW'(gf_q);
  assign phys_w = (pos_w < gf_lw) ? pos_w : pos_w + LW'(gap_w);

  assign req_ready_o = (state_q == StIdle);
  assign accept      = req_valid_i && req_ready_o;

  assign res_valid_o        = (state_q == StResp);
  assign res_o.ok           = ok_q;
  assign res_o.char_out     = rsel_q ? rd_data_i : '0;
  assign res_o.text_len     = FieldW'(len_w);
  assign res_o.gap_position = FieldW'(gf_q);

  always_comb begin
    state_d   = state_q;
    gf_d      = gf_q;
    gl_d      = gl_q;
    tgt_d     = tgt_q;
    cnt_d     = cnt_q;
    ok_d      = ok_q;
    rsel_d    = rsel_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    rd_en_o   = 1'b0;
    rd_addr_o = AW'(phys_w);
    wr_en_o   = 1'b0;
    wr_addr_o = AW'(gf_q);
    wr_data_o = char_in_i;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          ok_d    = 1'b0;
          rsel_d  = 1'b0;
          state_d = StResp;
          unique case (kind_i)
            KindRead: begin
              if (pos_w < len_lw) begin
                ok_d    = 1'b1;
                rsel_d  = 1'b1;
                rd_en_o = 1'b1;
              end
            end
            KindMove: begin
              if (pos_w <= len_lw) begin
                ok_d    = 1'b1;
                tgt_d   = CW'(pos_w);
                cnt_d   = '0;
                state_d = StMove;
              end
            end
            KindInsert: begin
              if (gf_q < gl_q) begin
                ok_d    = 1'b1;
                wr_en_o = 1'b1;
                gf_d    = gf_q + CW'(1);
              end
            end
            KindDelBefore: begin
              if (gf_q != '0) begin
                ok_d = 1'b1;
                gf_d = gf_q - CW'(1);
              end
            end
            KindDelAfter: begin
              if (gl_q != CW'(CAPACITY)) begin
                ok_d = 1'b1;
                gl_d = gl_q + CW'(1);
              end
            end
            KindDelRange: begin
              if ((pos_w < end_w) && (end_w <= len_lw)) begin
                ok_d    = 1'b1;
                tgt_d   = CW'(pos_w);
                cnt_d   = CW'(end_w - pos_w);
                state_d = StMove;
              end
            end
            KindClear: begin
              ok_d = 1'b1;
              gf_d = '0;
              gl_d = CW'(CAPACITY);
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end

      StMove: begin
        // retire the byte read last cycle
        wr_en_o   = wr_pend_q;
        wr_addr_o = wr_addr_q;
        wr_data_o = rd_data_i;
        if (gf_q < tgt_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(gl_q);
          wr_pend_d = 1'b1;
          wr_addr_d = AW'(gf_q);
          gf_d      = gf_q + CW'(1);
          gl_d      = gl_q + CW'(1);
        end else if (gf_q > tgt_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(gf_q - CW'(1));
          wr_pend_d = 1'b1;
          wr_addr_d = AW'(gl_q - CW'(1));
          gf_d      = gf_q - CW'(1);
          gl_d      = gl_q - CW'(1);
        end else begin
          // gap in place: widen it for a range delete
          gl_d    = gl_q + cnt_q;
          state_d = StResp;
        end
      end

      StResp: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      gf_q      <= '0;
      gl_q      <= CW'(CAPACITY);
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      gf_q      <= gf_d;
      gl_q      <= gl_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q     <= tgt_d;
    cnt_q     <= cnt_d;
    ok_q      <= ok_d;
    rsel_q    <= rsel_d;
    wr_addr_q <= wr_addr_d;
  end

endmodule

`default_nettype wire

### design/gap_buffer_text_store.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store: byte text store with a movable gap
// Read, insert, deletes at the gap and clear go straight from the accepted
// beat to the result state; move and range delete first walk the gap to its
// place, one byte copied per cycle through the single read and write port of
// the store. One request in work at a time.
// Reset clears the gap bounds and control state; store contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_text_store
  import gbts_pkg::*;
#(
  parameter int unsigned CAPACITY = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [KindW-1:0]  kind_i,
  input  wire logic [FieldW-1:0] position_i,
  input  wire logic [FieldW-1:0] end_position_i,
  input  wire logic [ByteW-1:0]  char_in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   ok_o,
  output logic      [ByteW-1:0]  char_out_o,
  output logic      [FieldW-1:0] text_len_o,
  output logic      [FieldW-1:0] gap_position_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  // sequencer to output register
  logic res_valid, res_ready;
  res_t res;

  // store ports
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    rd_data, wr_data;

  // output register
  logic out_valid_q, out_valid_d;
  res_t out_q;

  gbts_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid_i),
    .req_ready_o    (in_ready_o),
    .kind_i         (kind_i),
    .position_i     (position_i),
    .end_position_i (end_position_i),
    .char_in_i      (char_in_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data)
  );

  gbts_mem #(
    .CAPACITY(CAPACITY)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Take a new result whenever the output register is empty or its beat
  // leaves this cycle; otherwise hold the sequencer in its result state.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload needs no reset: load it together with the valid flag.
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_q.ok;
  assign char_out_o     = out_q.char_out;
  assign text_len_o     = out_q.text_len;
  assign gap_position_o = out_q.gap_position;

endmodule

`default_nettype wire
